[hw/rtl/scaf_pkg.sv]
// ----------------------------------------------------------------------------
// Scancode translator package
// Shared constants, result type and US set-1 keymap lookups.
// ----------------------------------------------------------------------------
package scaf_pkg;

   localparam int RING_DEPTH = 64;
   localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

   localparam logic [7:0] KEY_LSHIFT_MAKE  = 8'h2A;
   localparam logic [7:0] KEY_RSHIFT_MAKE  = 8'h36;
   localparam logic [7:0] KEY_LSHIFT_BREAK = 8'hAA;
   localparam logic [7:0] KEY_RSHIFT_BREAK = 8'hB6;
   localparam logic [7:0] KEY_CAPS_MAKE    = 8'h3A;
   localparam logic [7:0] KEY_TABLE_SIZE   = 8'h3A;
   localparam logic [6:0] ASCII_ESC        = 7'h1B;

   localparam logic FUNC_KEY  = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // Result flags carried from the work stage to the output register.
   typedef struct packed {
      logic read_valid;
      logic not_empty;
      logic dropped;
   } rsp_flags_type;

   // Unshifted US layout.
   function automatic logic [6:0] plain_char(input logic [5:0] code);
      logic [6:0] ch;
      case (code)
         6'h01: ch = ASCII_ESC;
         6'h02: ch = 7'h31;  6'h03: ch = 7'h32;  6'h04: ch = 7'h33;  6'h05: ch = 7'h34;
         6'h06: ch = 7'h35;  6'h07: ch = 7'h36;  6'h08: ch = 7'h37;  6'h09: ch = 7'h38;
         6'h0A: ch = 7'h39;  6'h0B: ch = 7'h30;  6'h0C: ch = 7'h2D;  6'h0D: ch = 7'h3D;
         6'h0E: ch = 7'h08;  6'h0F: ch = 7'h09;
         6'h10: ch = 7'h71;  6'h11: ch = 7'h77;  6'h12: ch = 7'h65;  6'h13: ch = 7'h72;
         6'h14: ch = 7'h74;  6'h15: ch = 7'h79;  6'h16: ch = 7'h75;  6'h17: ch = 7'h69;
         6'h18: ch = 7'h6F;  6'h19: ch = 7'h70;  6'h1A: ch = 7'h5B;  6'h1B: ch = 7'h5D;
         6'h1C: ch = 7'h0A;  6'h1E: ch = 7'h61;  6'h1F: ch = 7'h73;
         6'h20: ch = 7'h64;  6'h21: ch = 7'h66;  6'h22: ch = 7'h67;  6'h23: ch = 7'h68;
         6'h24: ch = 7'h6A;  6'h25: ch = 7'h6B;  6'h26: ch = 7'h6C;  6'h27: ch = 7'h3B;
         6'h28: ch = 7'h27;  6'h29: ch = 7'h60;  6'h2B: ch = 7'h5C;  6'h2C: ch = 7'h7A;
         6'h2D: ch = 7'h78;  6'h2E: ch = 7'h63;  6'h2F: ch = 7'h76;
         6'h30: ch = 7'h62;  6'h31: ch = 7'h6E;  6'h32: ch = 7'h6D;  6'h33: ch = 7'h2C;
         6'h34: ch = 7'h2E;  6'h35: ch = 7'h2F;  6'h37: ch = 7'h2A;  6'h39: ch = 7'h20;
         default: ch = 7'h00;
      endcase
      return ch;
   endfunction

   // Shifted US layout.
   function automatic logic [6:0] shifted_char(input logic [5:0] code);
      logic [6:0] ch;
      case (code)
         6'h01: ch = ASCII_ESC;
         6'h02: ch = 7'h21;  6'h03: ch = 7'h40;  6'h04: ch = 7'h23;  6'h05: ch = 7'h24;
         6'h06: ch = 7'h25;  6'h07: ch = 7'h5E;  6'h08: ch = 7'h26;  6'h09: ch = 7'h2A;
         6'h0A: ch = 7'h28;  6'h0B: ch = 7'h29;  6'h0C: ch = 7'h5F;  6'h0D: ch = 7'h2B;
         6'h0E: ch = 7'h08;  6'h0F: ch = 7'h09;
         6'h10: ch = 7'h51;  6'h11: ch = 7'h57;  6'h12: ch = 7'h45;  6'h13: ch = 7'h52;
         6'h14: ch = 7'h54;  6'h15: ch = 7'h59;  6'h16: ch = 7'h55;  6'h17: ch = 7'h49;
         6'h18: ch = 7'h4F;  6'h19: ch = 7'h50;  6'h1A: ch = 7'h7B;  6'h1B: ch = 7'h7D;
         6'h1C: ch = 7'h0A;  6'h1E: ch = 7'h41;  6'h1F: ch = 7'h53;
         6'h20: ch = 7'h44;  6'h21: ch = 7'h46;  6'h22: ch = 7'h47;  6'h23: ch = 7'h48;
         6'h24: ch = 7'h4A;  6'h25: ch = 7'h4B;  6'h26: ch = 7'h4C;  6'h27: ch = 7'h3A;
         6'h28: ch = 7'h22;  6'h29: ch = 7'h7E;  6'h2B: ch = 7'h7C;  6'h2C: ch = 7'h5A;
         6'h2D: ch = 7'h58;  6'h2E: ch = 7'h43;  6'h2F: ch = 7'h56;
         6'h30: ch = 7'h42;  6'h31: ch = 7'h4E;  6'h32: ch = 7'h4D;  6'h33: ch = 7'h3C;
         6'h34: ch = 7'h3E;  6'h35: ch = 7'h3F;  6'h37: ch = 7'h2A;  6'h39: ch = 7'h20;
         default: ch = 7'h00;
      endcase
      return ch;
   endfunction

   // Next ring position with wrap at the ring depth.
   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] pos);
      logic [IDX_W-1:0] nxt;
      if (pos == IDX_W'(RING_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = pos + IDX_W'(1);
      end
      return nxt;
   endfunction

endpackage

[hw/rtl/scancode_to_ascii_fifo.sv]
// ----------------------------------------------------------------------------
// Scancode to ASCII character ring
// Translates set-1 scancodes to ASCII into a ring and serves read requests.
// ----------------------------------------------------------------------------
// A result transaction passes the request register and then the result register before it is offered.
// Throughput: one request transaction per cycle, limited only by rsp_tready.
// The single-port character ring (one write or one registered read per cycle) sets that rate.
// Reset (synchronous, active high) empties the ring and clears shift and caps lock.
// Ring contents are not cleared; only entries already written are ever read.
module scancode_to_ascii_fifo
   import scaf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] scancode
   input  logic        req_tuser,   // [0] func: 0 = scancode byte, 1 = read one character
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [0] read_valid, [7:1] read_char, [8] not_empty,
                                    // [9] dropped, [15:10] zero
);

   // The request register holds one accepted transaction. The work stage
   // translates it, updates the modifier flags and ring indexes, and writes or
   // reads the ring. The result register then holds the finished transaction.
   // The pipeline moves whenever the result register is empty or being taken.

   logic                  req_valid_ff, req_valid_in;
   logic                  req_func_ff;
   logic [7:0]            req_code_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_flags_type         rsp_flags_ff, rsp_flags_in;

   logic [IDX_W-1:0]      wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                  shift_held_ff, shift_held_in;
   logic                  caps_latched_ff, caps_latched_in;

   logic [6:0]            char_store_ff [RING_DEPTH];
   logic [6:0]            rd_data_ff;

   logic                  advance;
   logic                  work;
   logic                  key_step;
   logic [6:0]            table_char;
   logic [6:0]            key_char;
   logic                  is_letter;
   logic                  push_req;
   logic                  ring_full;
   logic                  push;
   logic                  pop;
   logic [IDX_W-1:0]      wr_next;

   // The pipeline advances when the output slot is free or is being emptied.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !req_valid_ff || advance;
   assign work       = req_valid_ff && advance;
   assign key_step   = (req_func_ff == FUNC_KEY);

   // Table lookup. Break codes and codes beyond the table give no character;
   // shift make codes hit empty table slots and give none either.
   always_comb begin
      if (req_code_ff[7] || (req_code_ff >= KEY_TABLE_SIZE)) begin
         table_char = 7'h00;
      end else if (shift_held_ff) begin
         table_char = shifted_char(req_code_ff[5:0]);
      end else begin
         table_char = plain_char(req_code_ff[5:0]);
      end
   end

   // Caps lock flips the case of letters only.
   assign is_letter = ((table_char >= 7'h61) && (table_char <= 7'h7A)) ||
                      ((table_char >= 7'h41) && (table_char <= 7'h5A));
   assign key_char  = (caps_latched_ff && is_letter) ? (table_char ^ 7'h20) : table_char;

   // The ring keeps one slot free, so it is full when the write index would
   // catch up with the read index.
   assign wr_next   = ring_next(wr_idx_ff);
   assign ring_full = (wr_next == rd_idx_ff);
   assign push_req  = key_step && (key_char != 7'h00);
   assign push      = push_req && !ring_full;
   assign pop       = !key_step && (wr_idx_ff != rd_idx_ff);

   // Modifier and index updates.
   always_comb begin
      shift_held_in   = shift_held_ff;
      caps_latched_in = caps_latched_ff;
      wr_idx_in       = wr_idx_ff;
      rd_idx_in       = rd_idx_ff;
      if (work) begin
         if (key_step) begin
            if ((req_code_ff == KEY_LSHIFT_MAKE) || (req_code_ff == KEY_RSHIFT_MAKE)) begin
               shift_held_in = 1'b1;
            end else if ((req_code_ff == KEY_LSHIFT_BREAK) ||
                         (req_code_ff == KEY_RSHIFT_BREAK)) begin
               shift_held_in = 1'b0;
            end else if (req_code_ff == KEY_CAPS_MAKE) begin
               caps_latched_in = !caps_latched_ff;
            end
         end
         if (push) begin
            wr_idx_in = wr_next;
         end
         if (pop) begin
            rd_idx_in = ring_next(rd_idx_ff);
         end
      end
   end

   // Pipeline valid flags and the result flags.
   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_tready) begin
         req_valid_in = req_tvalid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = req_valid_ff;
      end
      rsp_flags_in.read_valid = pop;
      rsp_flags_in.not_empty  = (wr_idx_in != rd_idx_in);
      rsp_flags_in.dropped    = push_req && ring_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         wr_idx_ff       <= '0;
         rd_idx_ff       <= '0;
         shift_held_ff   <= 1'b0;
         caps_latched_ff <= 1'b0;
      end else begin
         req_valid_ff    <= req_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         wr_idx_ff       <= wr_idx_in;
         rd_idx_ff       <= rd_idx_in;
         shift_held_ff   <= shift_held_in;
         caps_latched_ff <= caps_latched_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tready) begin
         req_func_ff <= req_tuser;
         req_code_ff <= req_tdata;
      end
      if (work) begin
         rsp_flags_ff <= rsp_flags_in;
      end
   end

   // Character ring: one write or one registered read per cycle. A read only
   // ever targets an entry written in an earlier cycle.
   always_ff @(posedge clock) begin
      if (work && push) begin
         char_store_ff[wr_idx_ff] <= key_char;
      end
      if (work && pop) begin
         rd_data_ff <= char_store_ff[rd_idx_ff];
      end
   end

   // The character field reads as zero unless this transaction popped one.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0,
                        rsp_flags_ff.dropped,
                        rsp_flags_ff.not_empty,
                        rsp_flags_ff.read_valid ? rd_data_ff : 7'h00,
                        rsp_flags_ff.read_valid};

`ifndef SYNTHESIS
   // A transaction either pops or pushes, never reports both a read and a drop.
   a_pop_not_dropped : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_flags_ff.read_valid) |-> !rsp_flags_ff.dropped)
      else $error("read result also flagged a dropped character");

   // A character is only dropped when the ring is full, so it cannot be empty.
   a_drop_not_empty : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_flags_ff.dropped) |-> rsp_flags_ff.not_empty)
      else $error("dropped character reported with an empty ring");

   // A shift make code leaves shift held.
   a_shift_make : assert property (@(posedge clock) disable iff (reset)
      (work && key_step &&
       ((req_code_ff == KEY_LSHIFT_MAKE) || (req_code_ff == KEY_RSHIFT_MAKE)))
      |=> shift_held_ff)
      else $error("shift make code did not set shift");

   // Ring indexes move only while a transaction is processed.
   a_idx_hold : assert property (@(posedge clock) disable iff (reset)
      !work |=> ($stable(wr_idx_ff) && $stable(rd_idx_ff)))
      else $error("ring index changed without a transaction");
`endif

endmodule
